### sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### sv/isr_pkg.sv
// Shared types, constants and the two-bit restoring root step.
// Used by every module of the integer square root core; no dependencies.
package isr_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned RootW       = 16;
  localparam int unsigned RemW        = RootW + 1;
  localparam int unsigned NumSteps    = 16;
  localparam int unsigned StepsPerStg = 2;
  localparam int unsigned NumStages   = NumSteps / StepsPerStg;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } isr_data_t;

  // One restoring step: bring down a bit pair, try 4r+1 against the remainder.
  function automatic isr_data_t isr_step(isr_data_t d, logic [1:0] pair);
    logic [RootW-1:0] r_sh;
    logic [RemW-1:0]  trial;
    logic [RemW+1:0]  rem_c;
    isr_data_t        q;
    r_sh  = {d.root[RootW-2:0], 1'b0};
    trial = {r_sh, 1'b1};
    rem_c = {d.rem, pair};
    q     = d;
    if (rem_c >= {2'b00, trial}) begin
      q.root = r_sh | RootW'(1);
      q.rem  = RemW'(rem_c - {2'b00, trial});
    end else begin
      q.root = r_sh;
      q.rem  = rem_c[RemW-1:0];
    end
    return q;
  endfunction

endpackage

### sv/isr_stage.sv
// One pipeline stage of the root recurrence: two restoring steps, registered.
// Depends on isr_pkg for the data type and the step function.
module isr_stage import isr_pkg::*; #(
  parameter int unsigned StageIdx = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  isr_data_t data_i,
  output logic      valid_o,
  output isr_data_t data_o
);

  localparam int unsigned HiBit0 = DataW - 1 - 2 * StepsPerStg * StageIdx;
  localparam int unsigned HiBit1 = HiBit0 - 2;

  isr_data_t mid, data_d, data_q;
  logic      valid_q;

  always_comb begin
    mid    = isr_step(data_i, data_i.value[HiBit0 -: 2]);
    data_d = isr_step(mid, data_i.value[HiBit1 -: 2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload needs no reset; hold it while stalled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/isr_round.sv
// Final stage: round the floor root; pass through 0, 1 and top-bit-set values.
// Depends on isr_pkg. The remainder left by the recurrence is value - root^2.
module isr_round import isr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  isr_data_t        data_i,
  output logic             valid_o,
  output logic [DataW-1:0] root_o
);

  logic             pass_thru;
  logic [RootW:0]   r_ext;
  logic [RootW:0]   r_inc;
  logic [DataW-1:0] root_d, root_q;
  logic             valid_q;

  always_comb begin
    pass_thru = data_i.value[DataW-1] || (data_i.value <= DataW'(1));
    r_ext     = {1'b0, data_i.root};
    r_inc     = r_ext;
    // Round up when the remainder reaches root - 1.
    if ({{(RootW+1-RemW){1'b0}}, data_i.rem} >= (r_ext - (RootW+1)'(1))) begin
      r_inc = r_ext + (RootW+1)'(1);
    end
    root_d = pass_thru ? data_i.value : {{(DataW-RootW-1){1'b0}}, r_inc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign root_o  = root_q;

endmodule

### sv/integer_square_root_rounded_core.sv
// Top level of the rounded integer square root core.
// Depends on isr_pkg, isr_stage and isr_round.
//
//  Channel  | Direction | Payload (low bit up)     | Handshake
//  s_axis   | in        | tdata[31:0] = value      | tvalid / tready
//  m_axis   | out       | tdata[31:0] = root       | tvalid / tready
//
// One operand enters per cycle while the pipeline advances; each result passes
// through eight stages of two root steps each, then one rounding stage.
// Reset clears only the valid bits of the stages and the output.
// The whole pipeline advances together; it holds only while a result waits
// at the output and m_axis_tready is low, and bubbles stay in place while it holds.
module integer_square_root_rounded_core import isr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,   // [31:0] value
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata    // [31:0] root
);

  logic      advance;
  logic      stg_valid [NumStages+1];
  isr_data_t stg_data  [NumStages+1];

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  assign stg_valid[0] = s_axis_tvalid;
  assign stg_data[0]  = '{value: s_axis_tdata, rem: '0, root: '0};

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    isr_stage #(
      .StageIdx (g)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (stg_valid[g]),
      .data_i  (stg_data[g]),
      .valid_o (stg_valid[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  isr_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (stg_valid[NumStages]),
    .data_i  (stg_data[NumStages]),
    .valid_o (m_axis_tvalid),
    .root_o  (m_axis_tdata)
  );

endmodule

### sv/isr_checker.sv
// Port-level checks for the rounded integer square root core, bound to the top.
// Depends on assert_macros.svh and isr_pkg.
`include "assert_macros.svh"

module isr_checker import isr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [DataW-1:0] s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [DataW-1:0] m_axis_tdata
);

  // A rounded root fits 16 bits; anything wider must be a passed-through negative.
  `ASSERT_ALWAYS(a_root_range, m_axis_tvalid |-> (m_axis_tdata[DataW-1:RootW] == '0) || m_axis_tdata[DataW-1], "root out of range")
  // Input side stalls only behind a held result.
  `ASSERT_ALWAYS(a_stall_cause, !s_axis_tready |-> m_axis_tvalid, "input stalled without a waiting result")
  `ASSERT_ALWAYS(a_ready_follows, m_axis_tready |-> s_axis_tready, "input not ready while output drains")
  // Hold a stalled result.
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind integer_square_root_rounded_core isr_checker u_isr_checker (.*);
